// File: rtl/abisv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abisv_pkg;

  // register map, index = byte address / 4
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_LENGTH  = 2'd2;

  localparam int unsigned PLEN_W = 13;
  localparam int unsigned POS_W  = 13;

  localparam logic [31:0]       MAGIC_RESET   = 32'h434F_5354;
  localparam logic [31:0]       VERSION_RESET = 32'd1;
  localparam logic [PLEN_W-1:0] LENGTH_RESET  = 13'd256;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [POS_W-1:0] HDR_BYTES = 13'd20;
  localparam logic [POS_W-1:0] POS_MAX   = 13'h1FFF;
  localparam logic [POS_W-1:0] POS_MAGIC = 13'd3;
  localparam logic [POS_W-1:0] POS_VER   = 13'd7;
  localparam logic [POS_W-1:0] POS_SEQ   = 13'd11;
  localparam logic [POS_W-1:0] POS_LEN   = 13'd15;
  localparam logic [POS_W-1:0] POS_CRC   = 13'd19;

  localparam logic [31:0] SEQ_NONE = 32'd1;

  typedef struct packed {
    logic       slot;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic        checked_slot;
    logic        checked_valid;
    logic        any_valid;
    logic        newest_slot;
    logic [31:0] next_sequence;
    logic        target_slot;
  } out_item_t;

  // verdict of one finished image
  typedef struct packed {
    logic        slot;
    logic        valid;
    logic [31:0] sequence_no;
  } img_res_t;

  // reflected crc-32, one byte, eight bit steps unrolled
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/abisv_image_check.sv
`timescale 1ns / 1ps
`default_nettype none

module abisv_image_check
  import abisv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              item_accept,
  input  wire in_item_t          item,
  input  wire logic [31:0]       magic,
  input  wire logic [31:0]       version,
  input  wire logic [PLEN_W-1:0] plen,
  input  wire logic              len_ok,
  output img_res_t               res
);

  logic [31:0]      crc_r, crc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic             hdr_ok_r, hdr_ok_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [31:0]      icrc_r, icrc_nxt;
  logic [POS_W:0]   total;
  logic             size_ok;

  assign total = {1'b0, HDR_BYTES} + {1'b0, plen};

  always_comb begin
    crc_nxt    = crc_r;
    shift_nxt  = shift_r;
    hdr_ok_nxt = hdr_ok_r;
    seq_nxt    = seq_r;
    icrc_nxt   = icrc_r;
    if (pos_r < HDR_BYTES) begin
      shift_nxt = {item.data_byte, shift_r[31:8]};
      if (pos_r == POS_MAGIC && shift_nxt != magic) hdr_ok_nxt = 1'b0;
      if (pos_r == POS_VER && shift_nxt != version) hdr_ok_nxt = 1'b0;
      if (pos_r == POS_SEQ) seq_nxt = shift_nxt;
      if (pos_r == POS_LEN && shift_nxt != {19'd0, plen}) hdr_ok_nxt = 1'b0;
      if (pos_r == POS_CRC) icrc_nxt = shift_nxt;
    end else if ({1'b0, pos_r} < total) begin
      crc_nxt = crc_byte(crc_r, item.data_byte);
    end else begin
      hdr_ok_nxt = 1'b0;   // byte past the expected size
    end
    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + POS_W'(1);
  end

  assign size_ok         = ({1'b0, pos_r} + (POS_W+1)'(1)) == total;
  assign res.slot        = item.slot;
  assign res.valid       = hdr_ok_nxt && len_ok && size_ok && ((~crc_nxt) == icrc_nxt);
  assign res.sequence_no = seq_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (item_accept && item.last)) begin
      crc_r    <= CRC_INIT;
      pos_r    <= '0;
      shift_r  <= '0;
      hdr_ok_r <= 1'b1;
      seq_r    <= '0;
      icrc_r   <= '0;
    end else if (item_accept) begin
      crc_r    <= crc_nxt;
      pos_r    <= pos_nxt;
      shift_r  <= shift_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      seq_r    <= seq_nxt;
      icrc_r   <= icrc_nxt;
    end
  end

  // a finished image always restarts the byte count
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (item_accept && item.last) |=> (pos_r == '0 && hdr_ok_r && crc_r == CRC_INIT))
    else $error("image state not restarted after last byte");

endmodule

`default_nettype wire

// File: rtl/ab_image_slot_validator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake           | payload
// in_      | input     | in_valid / in_stall   | in_data  (slot, data_byte, last)
// out_     | output    | out_valid / out_stall | out_data (one item per last byte)
// cfg      | input     | apb psel/penable      | magic, version, payload length
//
// one byte item per cycle while in_stall is low; the per-byte crc is an
// eight-step unrolled update so the image checker never holds the input
// a last byte's verdict is registered at the edge that takes it and moves on
// to the output register once that is free or draining, with the slot table update and
// newest-slot pick
// rst_n is synchronous; it clears the image state, both slot entries and the
// pipeline valids and loads the register defaults
// out_stall backs up through the verdict register to in_stall

module ab_image_slot_validator_unit
  import abisv_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [31:0]       magic_r;
  logic [31:0]       version_r;
  logic [PLEN_W-1:0] plen_r;
  logic              cfg_wr;
  logic              len_ok;
  logic [POS_W:0]    total;

  // pipeline
  logic      in_acc;
  img_res_t  img_res;
  logic      s1_valid_r, s1_valid_nxt;
  img_res_t  s1_r;
  logic      s1_adv;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_r, out_nxt;

  // slot table
  logic        slot_valid_r [2];
  logic [31:0] slot_seq_r   [2];
  logic        va, vb;
  logic [31:0] seq_a, seq_b;
  logic [31:0] seq_diff;
  logic        newest_b;

  // ---------------------------------------------------------------- apb
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= MAGIC_RESET;
      version_r <= VERSION_RESET;
      plen_r    <= LENGTH_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_MAGIC:   magic_r   <= pwdata;
        REG_VERSION: version_r <= pwdata;
        REG_LENGTH:  plen_r    <= pwdata[PLEN_W-1:0];
        default: ;   // unmapped, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MAGIC:   prdata = magic_r;
      REG_VERSION: prdata = version_r;
      REG_LENGTH:  prdata = {19'd0, plen_r};
      default:     prdata = '0;
    endcase
  end

  // length register must be in range and leave room in the byte counter
  assign total  = {1'b0, HDR_BYTES} + {1'b0, plen_r};
  assign len_ok = (plen_r >= 13'd4) && (32'(plen_r) <= 32'(MAX_PAYLOAD_BYTES))
                  && (total <= {1'b0, POS_MAX});

  // ---------------------------------------------------------------- flow control
  // verdict register moves on when the output register is free or drains
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------- stage 1: image checks
  abisv_image_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_accept (in_acc),
    .item        (in_data),
    .magic       (magic_r),
    .version     (version_r),
    .plen        (plen_r),
    .len_ok      (len_ok),
    .res         (img_res)
  );

  // only last bytes produce a verdict
  assign s1_valid_nxt = (s1_valid_r && !s1_adv) || (in_acc && in_data.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_data.last) begin
      s1_r <= img_res;
    end
  end

  // ---------------------------------------------------------------- stage 2: slot table, pick newest
  // table as it stands after this verdict lands
  always_comb begin
    va    = slot_valid_r[0];
    vb    = slot_valid_r[1];
    seq_a = slot_seq_r[0];
    seq_b = slot_seq_r[1];
    if (s1_r.slot) begin
      vb    = s1_r.valid;
      seq_b = s1_r.valid ? s1_r.sequence_no : 32'd0;
    end else begin
      va    = s1_r.valid;
      seq_a = s1_r.valid ? s1_r.sequence_no : 32'd0;
    end
  end

  // wrap-safe compare, a tie keeps slot a
  assign seq_diff = seq_a - seq_b;
  assign newest_b = (va && vb) ? seq_diff[31] : (vb && !va);

  always_comb begin
    out_nxt.checked_slot  = s1_r.slot;
    out_nxt.checked_valid = s1_r.valid;
    out_nxt.any_valid     = va || vb;
    out_nxt.newest_slot   = newest_b;
    out_nxt.next_sequence = (va || vb) ? ((newest_b ? seq_b : seq_a) + 32'd1) : SEQ_NONE;
    out_nxt.target_slot   = (va || vb) && !newest_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r[0] <= 1'b0;
      slot_valid_r[1] <= 1'b0;
      slot_seq_r[0]   <= '0;
      slot_seq_r[1]   <= '0;
    end else if (s1_adv) begin
      slot_valid_r[0] <= va;
      slot_valid_r[1] <= vb;
      slot_seq_r[0]   <= seq_a;
      slot_seq_r[1]   <= seq_b;
    end
  end

  // ---------------------------------------------------------------- output register
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------- checks
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with no verdict pending");

  a_last_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last) |=> s1_valid_r)
    else $error("last byte produced no verdict");

  a_none_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.any_valid) |->
      (out_data.next_sequence == SEQ_NONE && !out_data.target_slot && !out_data.newest_slot))
    else $error("empty slot table gave a sequence or target");

  a_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.target_slot == (out_data.any_valid && !out_data.newest_slot)))
    else $error("target slot disagrees with newest slot");

  a_checked_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (slot_valid_r[out_r.checked_slot] == out_r.checked_valid))
    else $error("slot table not updated with verdict");

endmodule

`default_nettype wire

// File: dv/ab_image_slot_validator_unit_tb.sv
`timescale 1ns / 1ps

module ab_image_slot_validator_unit_tb
  import abisv_pkg::*;
;

  localparam int unsigned MAX_BYTES  = 4096;
  localparam int unsigned LIMIT      = 2_000_000;
  localparam int unsigned DRAIN      = 20;   // idle wait once every owed verdict has come out
  localparam int unsigned SETTLE     = 10;   // idle cycles before a register write
  localparam int unsigned RAND_ITEMS = 560;
  localparam int unsigned RAND_IMGS  = 12;

  // plan rows: either a register setting or one image
  typedef enum logic [1:0] {ROW_CFG, ROW_IMG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic        slot;
    logic [31:0] magic;     // header word, or register value on a setting row
    logic [31:0] version;
    logic [31:0] seq;
    logic [31:0] len_word;  // header length word, or payload length register
    int          n_body;    // payload bytes built
    int          n_send;    // bytes sent, 0 for the whole image
    bit          bad_crc;
    bit          burst;     // no idling on either side
    bit          typed;     // verdict typed in by hand
    out_item_t   want;
  } row_t;

  typedef struct packed {
    bit        typed;
    out_item_t val;
  } tag_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ab_image_slot_validator_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register shadow, written only while the block is idle
  logic [31:0] m_magic;
  logic [31:0] m_version;
  logic [12:0] m_len;

  // image checker shadow
  logic [31:0] img_crc;
  logic [12:0] img_pos;
  logic [31:0] img_hdr;
  logic        img_ok;
  logic [31:0] img_seq;
  logic [31:0] img_crc_word;
  logic        slot_ok [2];
  logic [31:0] slot_seq [2];

  out_item_t verdict_q [$];  // verdicts still owed by the block
  tag_t      typed_q [$];    // one entry per last byte sent, hand-typed or not

  int unsigned cycles;
  int unsigned mismatches;
  int unsigned items_in;
  int unsigned images_in;
  bit          tx_burst;
  bit          rx_burst;
  bit          force_fast;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void image_clear();
    img_crc      = CRC_INIT;
    img_pos      = '0;
    img_hdr      = '0;
    img_ok       = 1'b1;
    img_seq      = '0;
    img_crc_word = '0;
  endfunction

  // advance the shadow by one accepted byte; returns 1 with the verdict on a last byte
  function automatic bit judge_byte(input in_item_t it, output out_item_t res);
    logic [31:0] total;
    logic [12:0] p;
    bit          len_ok;
    bit          ok;
    bit          any;
    bit          newest_b;
    logic [31:0] diff;
    total  = 32'(HDR_BYTES) + 32'(m_len);
    p      = img_pos;
    len_ok = (m_len >= 13'd4) && (32'(m_len) <= 32'(MAX_BYTES)) && (total <= 32'(POS_MAX));
    res    = '0;
    if (p < HDR_BYTES) begin
      img_hdr = {it.data_byte, img_hdr[31:8]};
      case (p)
        POS_MAGIC: if (img_hdr != m_magic) img_ok = 1'b0;
        POS_VER:   if (img_hdr != m_version) img_ok = 1'b0;
        POS_SEQ:   img_seq = img_hdr;
        POS_LEN:   if (img_hdr != 32'(m_len)) img_ok = 1'b0;
        POS_CRC:   img_crc_word = img_hdr;
        default:   ;
      endcase
    end else if (32'(p) < total) begin
      img_crc = crc32_step(img_crc, it.data_byte);
    end else begin
      img_ok = 1'b0;  // byte past the expected size
    end
    if (p != POS_MAX) img_pos = p + 13'd1;
    if (!it.last) return 1'b0;

    ok = img_ok && len_ok && (32'(p) + 32'd1 == total) && ((img_crc ^ CRC_INIT) == img_crc_word);
    slot_ok[it.slot]  = ok;
    slot_seq[it.slot] = ok ? img_seq : 32'd0;
    image_clear();

    // wrap-safe pick, a tie goes to slot a
    any  = slot_ok[0] || slot_ok[1];
    diff = slot_seq[0] - slot_seq[1];
    if (slot_ok[0] && slot_ok[1]) newest_b = diff[31];
    else newest_b = slot_ok[1] && !slot_ok[0];

    res.checked_slot  = it.slot;
    res.checked_valid = ok;
    res.any_valid     = any;
    res.newest_slot   = newest_b;
    res.next_sequence = any ? slot_seq[newest_b] + 32'd1 : SEQ_NONE;
    res.target_slot   = any && !newest_b;
    return 1'b1;
  endfunction

  function automatic out_item_t verdict(input logic s, ok, any, newest, input logic [31:0] nseq,
                                        input logic target);
    out_item_t v;
    v.checked_slot  = s;
    v.checked_valid = ok;
    v.any_valid     = any;
    v.newest_slot   = newest;
    v.next_sequence = nseq;
    v.target_slot   = target;
    return v;
  endfunction

  function automatic row_t mk_img(input logic s, input logic [31:0] magic, version, seq, len_word,
                                  input int n_body, n_send, input bit bad_crc);
    row_t r;
    r.kind     = ROW_IMG;
    r.slot     = s;
    r.magic    = magic;
    r.version  = version;
    r.seq      = seq;
    r.len_word = len_word;
    r.n_body   = n_body;
    r.n_send   = n_send;
    r.bad_crc  = bad_crc;
    r.burst    = 1'b0;
    r.typed    = 1'b0;
    r.want     = '0;
    return r;
  endfunction

  function automatic row_t mk_cfg(input logic [31:0] magic, version, len);
    row_t r;
    r          = mk_img(1'b0, magic, version, '0, len, 0, 0, 1'b0);
    r.kind     = ROW_CFG;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch (%s) want slot %0d ok %0d any %0d newest %0d next %h target %0d",
               what, want.checked_slot, want.checked_valid, want.any_valid, want.newest_slot,
               want.next_sequence, want.target_slot);
      $display("  got slot %0d ok %0d any %0d newest %0d next %h target %0d",
               got.checked_slot, got.checked_valid, got.any_valid, got.newest_slot,
               got.next_sequence, got.target_slot);
    end
  endtask

  // clock, free running
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // input side: every accepted byte goes through the shadow
  always @(posedge clk) begin : watch_in
    out_item_t res;
    tag_t      tag;
    if (rst_n && in_valid && !in_stall) begin
      items_in++;
      if (judge_byte(in_data, res)) begin
        images_in++;
        tag = typed_q.pop_front();
        verdict_q.push_back(tag.typed ? tag.val : res);
      end
    end
  end

  // output side: each accepted item against the oldest verdict owed
  always @(posedge clk) begin : watch_out
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        note_mismatch("no item expected", '0, out_data);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.checked_slot !== want.checked_slot ||
            out_data.checked_valid !== want.checked_valid ||
            out_data.any_valid !== want.any_valid ||
            out_data.newest_slot !== want.newest_slot ||
            out_data.next_sequence !== want.next_sequence ||
            out_data.target_slot !== want.target_slot)
          note_mismatch("field", want, out_data);
      end
    end
  end

  // result sink: random stall before each item, with stretches of none
  initial begin : result_sink
    int gap;
    forever begin
      if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
      gap = (rx_burst || force_fast) ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // one byte item: random gap, then hold until taken; valid stays high on return
  task automatic send_item(input in_item_t it);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
    gap = (tx_burst || force_fast) ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // header words, payload with its crc, cut or padded as the row says
  task automatic send_image(input row_t r);
    logic [7:0]  body [$];
    logic [7:0]  bytes [$];
    logic [31:0] words [5];
    logic [31:0] c;
    int          n;
    int          ncrc;
    in_item_t    it;
    tag_t        tag;
    body  = {};
    bytes = {};
    for (int i = 0; i < r.n_body; i++) body.push_back(8'($urandom));
    ncrc = (r.n_body < int'(m_len)) ? r.n_body : int'(m_len);
    c = CRC_INIT;
    for (int i = 0; i < ncrc; i++) c = crc32_step(c, body[i]);
    c = ~c;
    if (r.bad_crc) c ^= 32'd1 << $urandom_range(0, 31);
    words = '{r.magic, r.version, r.seq, r.len_word, c};
    for (int w = 0; w < 5; w++)
      for (int k = 0; k < 4; k++) bytes.push_back(words[w][8*k +: 8]);
    foreach (body[i]) bytes.push_back(body[i]);

    force_fast = r.burst;
    n = (r.n_send == 0) ? bytes.size() : r.n_send;
    for (int i = 0; i < n; i++) begin
      // slot only counts on the last byte, so the rest carry noise
      it.slot      = (i == n - 1) ? r.slot : 1'($urandom_range(0, 1));
      it.data_byte = (i < bytes.size()) ? bytes[i] : 8'($urandom);
      it.last      = (i == n - 1);
      if (it.last) begin
        tag.typed = r.typed;
        tag.val   = r.want;
        typed_q.push_back(tag);
      end
      send_item(it);
    end
    force_fast = 1'b0;
  endtask

  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
  endtask

  // drain, let the pipeline settle, write all three registers and read them back
  task automatic write_regs(input logic [31:0] mg, vr, ln);
    logic [31:0] rd;
    logic [31:0] want [3];
    logic [1:0]  idx [3];
    @(negedge clk) in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    apb_xfer(1'b1, REG_MAGIC, mg, rd);
    m_magic = mg;
    apb_xfer(1'b1, REG_VERSION, vr, rd);
    m_version = vr;
    apb_xfer(1'b1, REG_LENGTH, ln, rd);
    m_len = ln[12:0];
    want = '{mg, vr, {19'd0, ln[12:0]}};
    idx  = '{REG_MAGIC, REG_VERSION, REG_LENGTH};
    for (int i = 0; i < 3; i++) begin
      apb_xfer(1'b0, idx[i], 32'd0, rd);
      if (rd !== want[i]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch (register %0d readback) want %h got %h", idx[i], want[i], rd);
      end
    end
    @(negedge clk) begin
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // random register setting: mostly short payloads, some out of range
  task automatic random_setting();
    logic [31:0] mg;
    logic [31:0] vr;
    logic [12:0] ln;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 80) ln = 13'($urandom_range(4, 24));
    else if (pick < 88) ln = 13'($urandom_range(25, 64));
    else if (pick < 94) ln = 13'($urandom_range(0, 3));
    else ln = 13'($urandom_range(4097, 8191));
    mg = $urandom_range(0, 1) ? MAGIC_RESET : 32'($urandom);
    case ($urandom_range(0, 3))
      0:       vr = 32'd0;
      1:       vr = VERSION_RESET;
      2:       vr = '1;
      default: vr = $urandom;
    endcase
    write_regs(mg, vr, {19'($urandom), ln});
  endtask

  // mostly well-formed images, sequence numbers near the other slot's and near wrap
  task automatic random_image();
    row_t        r;
    logic        s;
    logic [31:0] other;
    logic [31:0] sq;
    int          nb;
    int          tot;
    int          kind;
    s     = $urandom_range(0, 1);
    other = slot_seq[!s];
    case ($urandom_range(0, 4))
      0:       sq = $urandom;
      1:       sq = other + 32'($urandom_range(0, 3));
      2:       sq = other - 32'($urandom_range(0, 3));
      3:       sq = (other ^ 32'h8000_0000) + 32'($urandom_range(0, 2)) - 32'd1;
      default: sq = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
    endcase
    nb  = (m_len <= 13'd64) ? int'(m_len) : $urandom_range(4, 30);
    tot = int'(HDR_BYTES) + nb;
    r   = mk_img(s, m_magic, m_version, sq, 32'(m_len), nb, 0, 1'b0);
    kind = $urandom_range(0, 99);
    if (kind < 65) ;
    else if (kind < 70) r.bad_crc = 1'b1;
    else if (kind < 74) r.magic ^= 32'd1 << $urandom_range(0, 31);
    else if (kind < 78) r.version ^= 32'd1 << $urandom_range(0, 31);
    else if (kind < 82) r.len_word ^= 32'd1 << $urandom_range(0, 31);
    else if (kind < 88) r.n_send = $urandom_range(1, tot - 1);
    else if (kind < 92) r.n_send = tot + $urandom_range(1, 4);
    else r = mk_img(s, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 12),
                    $urandom_range(1, 32), 1'b0);  // plain noise
    send_image(r);
  endtask

  initial begin : stimulus
    row_t        plan [$];
    row_t        r;
    int unsigned base_items;
    int unsigned base_images;

    // every input known from time zero
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_stall  = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    cycles     = 0;
    mismatches = 0;
    items_in   = 0;
    images_in  = 0;
    tx_burst   = 1'b0;
    rx_burst   = 1'b0;
    force_fast = 1'b0;
    m_magic    = MAGIC_RESET;
    m_version  = VERSION_RESET;
    m_len      = LENGTH_RESET;
    image_clear();
    slot_ok    = '{1'b0, 1'b0};
    slot_seq   = '{32'd0, 32'd0};

    // directed part: register defaults first, then the corner cases
    // a single byte image right after reset, nothing valid
    r = mk_img(1'b0, MAGIC_RESET, VERSION_RESET, 32'd0, 32'd256, 256, 1, 1'b0);
    r.typed = 1'b1;
    r.want  = verdict(1'b0, 1'b0, 1'b0, 1'b0, SEQ_NONE, 1'b0);
    plan.push_back(r);
    // good image in b under the reset registers, b becomes newest
    r = mk_img(1'b1, MAGIC_RESET, VERSION_RESET, 32'd5, 32'd256, 256, 0, 1'b0);
    r.typed = 1'b1;
    r.want  = verdict(1'b1, 1'b1, 1'b1, 1'b1, 32'd6, 1'b0);
    plan.push_back(r);
    // extreme register values and the shortest payload
    plan.push_back(mk_cfg(32'hFFFF_FFFF, 32'd0, 32'd4));
    plan.push_back(mk_img(1'b0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd4, 4, 0, 1'b0));
    plan.push_back(mk_img(1'b1, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd4, 4, 0, 1'b0));
    plan.push_back(mk_img(1'b0, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF, 32'd4, 4, 0, 1'b0));
    // bad crc in b, only a left
    r = mk_img(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd3, 32'd4, 4, 0, 1'b1);
    r.typed = 1'b1;
    r.want  = verdict(1'b1, 1'b0, 1'b1, 1'b0, 32'h8000_0000, 1'b1);
    plan.push_back(r);
    // wrong magic in a, nothing left
    r = mk_img(1'b0, 32'd0, 32'd0, 32'd3, 32'd4, 4, 0, 1'b0);
    r.typed = 1'b1;
    r.want  = verdict(1'b0, 1'b0, 1'b0, 1'b0, SEQ_NONE, 1'b0);
    plan.push_back(r);
    plan.push_back(mk_img(1'b1, 32'hFFFF_FFFF, 32'd1, 32'd3, 32'd4, 4, 0, 1'b0));   // version
    plan.push_back(mk_img(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd3, 32'd5, 4, 0, 1'b0));   // length word
    plan.push_back(mk_img(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd3, 32'd4, 4, 22, 1'b0));  // short
    plan.push_back(mk_img(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd3, 32'd4, 6, 0, 1'b0));   // long
    plan.push_back(mk_img(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd3, 32'd4, 4, 25, 1'b0));  // one extra
    // equal sequence numbers, a wins; bytes back to back
    r = mk_img(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd4, 4, 0, 1'b0);
    r.burst = 1'b1;
    plan.push_back(r);
    r = mk_img(1'b0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd4, 4, 0, 1'b0);
    r.burst = 1'b1;
    plan.push_back(r);
    // length register out of range: nothing can pass
    plan.push_back(mk_cfg(32'd0, 32'hFFFF_FFFF, 32'd3));
    plan.push_back(mk_img(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd9, 32'd3, 3, 0, 1'b0));
    plan.push_back(mk_cfg(32'd0, 32'hFFFF_FFFF, 32'd4097));
    plan.push_back(mk_img(1'b1, 32'd0, 32'hFFFF_FFFF, 32'd9, 32'd4097, 8, 0, 1'b0));
    plan.push_back(mk_cfg(32'd0, 32'hFFFF_FFFF, 32'd0));
    plan.push_back(mk_img(1'b0, 32'd0, 32'hFFFF_FFFF, 32'd9, 32'd0, 0, 0, 1'b0));
    plan.push_back(mk_cfg(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    plan.push_back(mk_img(1'b1, 32'd0, 32'hFFFF_FFFF, 32'd9, 32'd8191, 0, 1, 1'b0));
    // largest payload register, image cut short
    plan.push_back(mk_cfg(32'd0, 32'hFFFF_FFFF, 32'd4096));
    plan.push_back(mk_img(1'b0, 32'd0, 32'hFFFF_FFFF, 32'h1234_5678, 32'd4096, 20, 40, 1'b0));

    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_regs(plan[i].magic, plan[i].version, plan[i].len_word);
      else send_image(plan[i]);
    end

    // random part: short settings phases until enough bytes and images have gone through
    base_items  = items_in;
    base_images = images_in;
    while (items_in - base_items < RAND_ITEMS || images_in - base_images < RAND_IMGS) begin
      random_setting();
      repeat ($urandom_range(3, 8)) random_image();
    end

    // drain
    @(negedge clk) in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
